// ===== rtl/pfd_pkg.sv =====
// Shared types, letter codes and cell arithmetic for the Playfair digraph decryptor.
// Used by pfd_store and playfair_digraph_decrypt; depends on nothing else.
package pfd_pkg;

   localparam int unsigned SqSide   = 5;
   localparam int unsigned SqCells  = 25;
   localparam int unsigned Letters  = 26;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;
   typedef logic [1:0] command_type;

   localparam command_type CMD_KEY     = 2'd0;
   localparam command_type CMD_FINISH  = 2'd1;
   localparam command_type CMD_DECRYPT = 2'd2;
   localparam command_type CMD_UNUSED  = 2'd3;

   localparam letter_type LET_I = 5'd8;
   localparam letter_type LET_J = 5'd9;
   localparam letter_type LET_X = 5'd23;
   localparam letter_type LET_Z = 5'd25;

   localparam cell_type LAST_CELL = cell_type'(SqCells - 1);
   localparam coord_type LAST_COORD = coord_type'(SqSide - 1);

   typedef struct packed {
      logic       en;
      cell_type   slot;
      letter_type letter;
   } store_wr_type;

   typedef struct packed {
      logic       en;
      letter_type addr_a;
      letter_type addr_b;
   } pos_rd_type;

   typedef struct packed {
      logic     en;
      cell_type addr_a;
      cell_type addr_b;
   } sq_rd_type;

   function automatic letter_type fold_letter(input letter_type v);
      letter_type x;
      x = (v > LET_Z) ? LET_Z : v;
      return (x == LET_J) ? LET_I : x;
   endfunction

   function automatic coord_type cell_row(input cell_type p);
      coord_type r;
      if (p < cell_type'(SqSide))          r = 3'd0;
      else if (p < cell_type'(2 * SqSide)) r = 3'd1;
      else if (p < cell_type'(3 * SqSide)) r = 3'd2;
      else if (p < cell_type'(4 * SqSide)) r = 3'd3;
      else                                 r = 3'd4;
      return r;
   endfunction

   function automatic cell_type cell_index(input coord_type row, input coord_type col);
      cell_type r5;
      r5 = cell_type'({row, 2'b00}) + cell_type'(row);
      return r5 + cell_type'(col);
   endfunction

   function automatic coord_type cell_col(input cell_type p);
      return coord_type'(p - cell_index(cell_row(p), 3'd0));
   endfunction

   function automatic coord_type coord_dec(input coord_type c);
      return (c == 3'd0) ? LAST_COORD : coord_type'(c - 3'd1);
   endfunction

endpackage

// ===== rtl/pfd_store.sv =====
// Key square and letter position memories, one write port and two read ports each.
// Uses pfd_pkg for the letter, cell and port structure types.
module pfd_store (
   input  logic                  clock,
   input  pfd_pkg::store_wr_type wr,
   input  pfd_pkg::pos_rd_type   pos_rd,
   input  pfd_pkg::sq_rd_type    sq_rd,
   output pfd_pkg::cell_type     pos_data_a,
   output pfd_pkg::cell_type     pos_data_b,
   output pfd_pkg::letter_type   sq_data_a,
   output pfd_pkg::letter_type   sq_data_b
);

   pfd_pkg::letter_type key_square [pfd_pkg::SqCells];
   pfd_pkg::cell_type   letter_position [pfd_pkg::Letters];

   pfd_pkg::cell_type   pos_a_ff, pos_b_ff;
   pfd_pkg::letter_type sq_a_ff, sq_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_square[wr.slot]        <= wr.letter;
         letter_position[wr.letter] <= wr.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_rd.en) begin
         pos_a_ff <= letter_position[pos_rd.addr_a];
         pos_b_ff <= letter_position[pos_rd.addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (sq_rd.en) begin
         sq_a_ff <= key_square[sq_rd.addr_a];
         sq_b_ff <= key_square[sq_rd.addr_b];
      end
   end

   assign pos_data_a = pos_a_ff;
   assign pos_data_b = pos_b_ff;
   assign sq_data_a  = sq_a_ff;
   assign sq_data_b  = sq_b_ff;

endmodule

// ===== rtl/playfair_digraph_decrypt.sv =====
// Top level of the Playfair digraph decryptor: command sequencer, fill walk and result register.
// Depends on pfd_pkg and instantiates pfd_store.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_command, req_letter_a, req_letter_b, req_has_b
//   rsp      out        rsp_valid / rsp_stall  rsp_plain_a, rsp_plain_b, rsp_status
//
// A keyword letter, an unused command or a repeated finish completes in the cycle it is accepted;
// the first finish walks every letter code through ST_FILL, one step per letter, as the key
// square has one write port. A decrypt goes through ST_POS and ST_CELL, as the position and
// cell reads each wait on a memory; one before the square is finished skips both reads.
// Reset clears the state, used-letter flags, fill count, ready flag and response valid; the memories are not cleared.
// The input stalls while an item is in progress; a decrypt waits for a free result register.
module playfair_digraph_decrypt (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [4:0] req_letter_a,
   input  logic [4:0] req_letter_b,
   input  logic       req_has_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_plain_a,
   output logic [4:0] rsp_plain_b,
   output logic       rsp_status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_POS  = 2'd2;
   localparam logic [1:0] ST_CELL = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [pfd_pkg::Letters-1:0]     used_ff, used_in;
   pfd_pkg::cell_type               fill_ff, fill_in;
   logic                            ready_ff, ready_in;
   pfd_pkg::letter_type             walk_ff, walk_in;
   logic                            err_ff, err_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pfd_pkg::letter_type             rsp_a_ff, rsp_a_in;
   pfd_pkg::letter_type             rsp_b_ff, rsp_b_in;
   logic                            rsp_status_ff, rsp_status_in;

   logic                            accept;
   logic                            out_free;
   pfd_pkg::letter_type             place_let;
   logic                            place_try;
   pfd_pkg::store_wr_type           wr;
   pfd_pkg::pos_rd_type             pos_rd;
   pfd_pkg::sq_rd_type              sq_rd;
   pfd_pkg::cell_type               pos_a, pos_b;
   pfd_pkg::letter_type             sq_a, sq_b;
   pfd_pkg::coord_type              ra, ca, rb, cb;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      place_let = (state_ff == ST_FILL) ? walk_ff : pfd_pkg::fold_letter(req_letter_a);
      place_try = 1'b0;
      if (state_ff == ST_FILL) begin
         place_try = (walk_ff != pfd_pkg::LET_J);
      end else if (state_ff == ST_IDLE) begin
         place_try = accept && (req_command == pfd_pkg::CMD_KEY) && !ready_ff &&
                     (req_letter_a <= pfd_pkg::LET_Z);
      end
      wr.en     = place_try && !used_ff[place_let] && (fill_ff <= pfd_pkg::LAST_CELL);
      wr.slot   = fill_ff;
      wr.letter = place_let;
   end

   always_comb begin
      pos_rd.en     = accept && (req_command == pfd_pkg::CMD_DECRYPT) && ready_ff;
      pos_rd.addr_a = pfd_pkg::fold_letter(req_letter_a);
      pos_rd.addr_b = req_has_b ? pfd_pkg::fold_letter(req_letter_b) : pfd_pkg::LET_X;
   end

   always_comb begin
      ra = pfd_pkg::cell_row(pos_a);
      ca = pfd_pkg::cell_col(pos_a);
      rb = pfd_pkg::cell_row(pos_b);
      cb = pfd_pkg::cell_col(pos_b);
      sq_rd.en = (state_ff == ST_POS);
      if (ra == rb) begin
         sq_rd.addr_a = pfd_pkg::cell_index(ra, pfd_pkg::coord_dec(ca));
         sq_rd.addr_b = pfd_pkg::cell_index(rb, pfd_pkg::coord_dec(cb));
      end else if (ca == cb) begin
         sq_rd.addr_a = pfd_pkg::cell_index(pfd_pkg::coord_dec(ra), ca);
         sq_rd.addr_b = pfd_pkg::cell_index(pfd_pkg::coord_dec(rb), cb);
      end else begin
         sq_rd.addr_a = pfd_pkg::cell_index(ra, cb);
         sq_rd.addr_b = pfd_pkg::cell_index(rb, ca);
      end
   end

   pfd_store u_store (
      .clock      (clock),
      .wr         (wr),
      .pos_rd     (pos_rd),
      .sq_rd      (sq_rd),
      .pos_data_a (pos_a),
      .pos_data_b (pos_b),
      .sq_data_a  (sq_a),
      .sq_data_b  (sq_b)
   );

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      fill_in       = fill_ff;
      ready_in      = ready_ff;
      walk_in       = walk_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_status_in = rsp_status_ff;

      if (wr.en) begin
         used_in[place_let] = 1'b1;
         fill_in            = pfd_pkg::cell_type'(fill_ff + 5'd1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  pfd_pkg::CMD_FINISH: begin
                     if (!ready_ff) begin
                        walk_in  = '0;
                        state_in = ST_FILL;
                     end
                  end
                  pfd_pkg::CMD_DECRYPT: begin
                     err_in   = !ready_ff;
                     state_in = ready_ff ? ST_POS : ST_CELL;
                  end
                  pfd_pkg::CMD_KEY, pfd_pkg::CMD_UNUSED: begin
                     state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            walk_in = pfd_pkg::letter_type'(walk_ff + 5'd1);
            if (walk_ff == pfd_pkg::LET_Z) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POS: begin
            state_in = ST_CELL;
         end
         ST_CELL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_a_in      = err_ff ? '0 : sq_a;
               rsp_b_in      = err_ff ? '0 : sq_b;
               rsp_status_in = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         fill_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      err_ff        <= err_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_b_ff      <= rsp_b_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_plain_a = rsp_a_ff;
   assign rsp_plain_b = rsp_b_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// ===== verif/pfd_plain_check.sv =====
// Watches both channels of playfair_digraph_decrypt, predicts each plaintext pair and compares.
// Depends on pfd_pkg for the command codes, letter codes and square sizes.
module pfd_plain_check
   import pfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  command_type req_command,
   input  letter_type  req_letter_a,
   input  letter_type  req_letter_b,
   input  logic        req_has_b,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  letter_type  rsp_plain_a,
   input  letter_type  rsp_plain_b,
   input  logic        rsp_status,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          row_pairs,
   output int          col_pairs,
   output int          rect_pairs,
   output int          early_pairs
);

   typedef struct packed {
      letter_type plain_a;
      letter_type plain_b;
      logic       status;
   } plain_pair_type;

   plain_pair_type       plain_due[$];
   letter_type           sq_letter[SqCells];
   int                   letter_cell[Letters];
   logic [Letters-1:0]   in_square;
   int                   cells_filled;
   logic                 square_done;
   int                   failures;
   int                   results_seen;
   int                   n_row, n_col, n_rect, n_early;

   initial begin
      failures     = 0;
      results_seen = 0;
      n_row        = 0;
      n_col        = 0;
      n_rect       = 0;
      n_early      = 0;
   end

   function automatic int canonical_letter(input letter_type v);
      int x;
      x = (v > LET_Z) ? int'(LET_Z) : int'(v);
      if (x == int'(LET_J)) x = int'(LET_I);
      return x;
   endfunction

   task automatic add_to_square(input int code);
      if (code < int'(Letters) && code != int'(LET_J) && !in_square[code] &&
          cells_filled < int'(SqCells)) begin
         sq_letter[cells_filled] = letter_type'(code);
         letter_cell[code]       = cells_filled;
         in_square[code]         = 1'b1;
         cells_filled++;
      end
   endtask

   task automatic take_request(input command_type cmd, input letter_type a,
                               input letter_type b, input logic hb);
      int             la, lb, pa, pb, ra, ca, rb, cb, oa, ob;
      plain_pair_type due;
      case (cmd)
         CMD_KEY: begin
            if (!square_done && a <= LET_Z) add_to_square(canonical_letter(a));
         end
         CMD_FINISH: begin
            if (!square_done) begin
               for (int k = 0; k < int'(Letters); k++) add_to_square(k);
               square_done = 1'b1;
            end
         end
         CMD_DECRYPT: begin
            if (!square_done) begin
               due.plain_a = '0;
               due.plain_b = '0;
               due.status  = 1'b1;
               n_early++;
            end else begin
               la = canonical_letter(a);
               lb = hb ? canonical_letter(b) : int'(LET_X);
               pa = letter_cell[la];
               pb = letter_cell[lb];
               ra = pa / int'(SqSide);
               ca = pa % int'(SqSide);
               rb = pb / int'(SqSide);
               cb = pb % int'(SqSide);
               if (ra == rb) begin
                  oa = ra * int'(SqSide) + (ca + int'(SqSide) - 1) % int'(SqSide);
                  ob = rb * int'(SqSide) + (cb + int'(SqSide) - 1) % int'(SqSide);
                  n_row++;
               end else if (ca == cb) begin
                  oa = ((ra + int'(SqSide) - 1) % int'(SqSide)) * int'(SqSide) + ca;
                  ob = ((rb + int'(SqSide) - 1) % int'(SqSide)) * int'(SqSide) + cb;
                  n_col++;
               end else begin
                  oa = ra * int'(SqSide) + cb;
                  ob = rb * int'(SqSide) + ca;
                  n_rect++;
               end
               due.plain_a = sq_letter[oa];
               due.plain_b = sq_letter[ob];
               due.status  = 1'b0;
            end
            plain_due.push_back(due);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      plain_pair_type due;
      if (reset) begin
         plain_due.delete();
         in_square    = '0;
         cells_filled = 0;
         square_done  = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (plain_due.size() == 0) begin
               if (failures < 10)
                  $display("unexpected transfer: plain %0d %0d status %0d",
                           rsp_plain_a, rsp_plain_b, rsp_status);
               failures++;
            end else begin
               due = plain_due.pop_front();
               if (rsp_plain_a !== due.plain_a || rsp_plain_b !== due.plain_b ||
                   rsp_status !== due.status) begin
                  if (failures < 10)
                     $display("mismatch %0d: expected plain %0d %0d status %0d, got %0d %0d %0d",
                              results_seen, due.plain_a, due.plain_b, due.status,
                              rsp_plain_a, rsp_plain_b, rsp_status);
                  failures++;
               end
               results_seen++;
            end
         end
         if (req_valid && !req_stall)
            take_request(req_command, req_letter_a, req_letter_b, req_has_b);
      end
      pending     <= plain_due.size();
      fail_count  <= failures;
      checked     <= results_seen;
      row_pairs   <= n_row;
      col_pairs   <= n_col;
      rect_pairs  <= n_rect;
      early_pairs <= n_early;
   end

endmodule

// ===== verif/tb_playfair_digraph_decrypt.sv =====
// Testbench top for playfair_digraph_decrypt: clock, reset, request and response stimulus, verdict.
// Depends on pfd_pkg, the block itself and pfd_plain_check, which does the result checking.
module tb_playfair_digraph_decrypt;
   import pfd_pkg::*;

   localparam int RandomItems = 1880;
   localparam int QuietItems  = 250;
   localparam int CycleLimit  = 600000;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   command_type req_command  = CMD_UNUSED;
   letter_type  req_letter_a = '0;
   letter_type  req_letter_b = '0;
   logic        req_has_b    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   letter_type  rsp_plain_a;
   letter_type  rsp_plain_b;
   logic        rsp_status;

   int fail_count, pending, checked, row_pairs, col_pairs, rect_pairs, early_pairs;
   int idle_odds = 2;
   int requests  = 0;
   int cycles    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   playfair_digraph_decrypt DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_letter_a (req_letter_a),
      .req_letter_b (req_letter_b),
      .req_has_b    (req_has_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_plain_a  (rsp_plain_a),
      .rsp_plain_b  (rsp_plain_b),
      .rsp_status   (rsp_status)
   );

   pfd_plain_check plain_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_letter_a (req_letter_a),
      .req_letter_b (req_letter_b),
      .req_has_b    (req_has_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_plain_a  (rsp_plain_a),
      .rsp_plain_b  (rsp_plain_b),
      .rsp_status   (rsp_status),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .row_pairs    (row_pairs),
      .col_pairs    (col_pairs),
      .rect_pairs   (rect_pairs),
      .early_pairs  (early_pairs)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
         $display("tb_playfair_digraph_decrypt NOT OK");
         $finish;
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic letter_type any_letter();
      return ($urandom_range(0, 9) == 0) ? letter_type'($urandom_range(26, 31))
                                         : letter_type'($urandom_range(0, 25));
   endfunction

   task automatic offer(input command_type cmd, input letter_type a, input letter_type b,
                        input logic hb);
      if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_letter_a <= a;
      req_letter_b <= b;
      req_has_b    <= hb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int          n_key;
      int          pick;
      command_type cmd;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      offer(CMD_DECRYPT, 5'd0, 5'd31, 1'b1);
      offer(CMD_DECRYPT, LET_Z, 5'd0, 1'b0);
      offer(CMD_UNUSED, 5'd31, 5'd31, 1'b1);
      offer(CMD_KEY, LET_J, 5'd0, 1'b0);
      offer(CMD_KEY, 5'd31, 5'd0, 1'b0);
      offer(CMD_KEY, 5'd26, 5'd0, 1'b0);
      offer(CMD_KEY, LET_I, 5'd0, 1'b0);
      offer(CMD_KEY, LET_Z, 5'd0, 1'b0);
      offer(CMD_KEY, LET_Z, 5'd0, 1'b0);

      n_key = $urandom_range(0, 45);
      for (int k = 0; k < n_key; k++) begin
         pick = $urandom_range(0, 9);
         cmd  = (pick == 0) ? CMD_UNUSED : (pick == 1) ? CMD_DECRYPT : CMD_KEY;
         offer(cmd, any_letter(), any_letter(), 1'($urandom_range(0, 1)));
      end

      offer(CMD_FINISH, 5'd0, 5'd0, 1'b0);
      offer(CMD_FINISH, 5'd31, 5'd31, 1'b1);
      offer(CMD_KEY, 5'd0, 5'd0, 1'b0);
      offer(CMD_UNUSED, 5'd0, 5'd0, 1'b0);
      offer(CMD_DECRYPT, 5'd0, LET_Z, 1'b1);
      offer(CMD_DECRYPT, 5'd31, 5'd31, 1'b1);
      offer(CMD_DECRYPT, LET_J, 5'd0, 1'b0);
      offer(CMD_DECRYPT, LET_I, LET_J, 1'b1);
      offer(CMD_DECRYPT, LET_X, LET_X, 1'b1);
      offer(CMD_DECRYPT, 5'd0, 5'd0, 1'b0);
      offer(CMD_DECRYPT, 5'd31, 5'd26, 1'b1);
      offer(CMD_DECRYPT, LET_J, LET_J, 1'b0);
      drain();

      for (int k = 0; k < RandomItems; k++) begin
         if (k >= RandomItems - QuietItems) idle_odds = 0;
         else if (k % 150 == 0) idle_odds = $urandom_range(0, 4);
         if (k == RandomItems / 2) drain();
         pick = $urandom_range(0, 99);
         if (pick < 88) cmd = CMD_DECRYPT;
         else if (pick < 94) cmd = CMD_KEY;
         else if (pick < 97) cmd = CMD_FINISH;
         else cmd = CMD_UNUSED;
         offer(cmd, any_letter(), any_letter(), 1'($urandom_range(0, 4) != 0));
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests; checked %0d pairs, %0d before the square was complete.",
               requests, checked, early_pairs);
      $display("Pairs by rule: %0d same row, %0d same column, %0d rectangle.",
               row_pairs, col_pairs, rect_pairs);
      if (pending != 0)
         $display("%0d expected results never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_playfair_digraph_decrypt OK");
      end else begin
         $display("tb_playfair_digraph_decrypt NOT OK");
      end
      $finish;
   end

endmodule
